FILE: hdl/eitt_pkg.sv
// ---------------------------------------------------------------------------
// eitt_pkg: shared types and constants for the id translation table
// Local id width, action and status codes, cell control struct.
// ---------------------------------------------------------------------------
package eitt_pkg;

  localparam int ENTRIES = 256;
  localparam int LW = $clog2(ENTRIES);   // local id width
  localparam int CW = LW + 1;            // counter width (holds ENTRIES)

  localparam logic [2:0] ACT_DOWN    = 3'd0;
  localparam logic [2:0] ACT_UP      = 3'd1;
  localparam logic [2:0] ACT_FREE    = 3'd2;
  localparam logic [2:0] ACT_RM_REM  = 3'd3;
  localparam logic [2:0] ACT_RM_LOC  = 3'd4;
  localparam logic [2:0] ACT_CLIENT  = 3'd5;

  localparam logic [2:0] ST_HIT  = 3'd0;
  localparam logic [2:0] ST_NEW  = 3'd1;
  localparam logic [2:0] ST_MISS = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // Write command broadcast to every cell; each cell matches its own index.
  typedef struct packed {
    logic          wr;      // write entry
    logic          set_v;   // new valid value
    logic          set_id;  // also load remote id
    logic [LW-1:0] idx;
    logic [31:0]   rid;
  } eitt_wr_t;

  // Search beat travelling along the chain.
  typedef struct packed {
    logic          act;     // a search is moving
    logic          by_loc;  // match on local index instead of remote id
    logic          rng;     // key is a local id in range
    logic          found;
    logic [LW-1:0] loc;
    logic [31:0]   key;
    logic [31:0]   rid;     // remote id of the matching entry
  } eitt_srch_t;

endpackage

FILE: hdl/eitt_ram.sv
// ---------------------------------------------------------------------------
// eitt_ram: generic single port RAM
// One write or one read a cycle, registered read data.
// ---------------------------------------------------------------------------
module eitt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: hdl/eitt_cell.sv
// ---------------------------------------------------------------------------
// eitt_cell: one table entry of the search chain
// Holds valid and remote id; compares the passing search beat.
// ---------------------------------------------------------------------------
module eitt_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [eitt_pkg::LW-1:0] my_idx,
  input  eitt_pkg::eitt_wr_t     wr,
  input  eitt_pkg::eitt_srch_t   s_in,
  output eitt_pkg::eitt_srch_t   s_out
);
  logic        valid;
  logic [31:0] rid;
  logic        match;
  logic        hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.wr && wr.idx == my_idx) begin
      valid <= wr.set_v;
    end
    if (wr.wr && wr.set_id && wr.idx == my_idx) begin
      rid <= wr.rid;
    end
  end

  assign match = s_in.by_loc ? (s_in.rng && s_in.key[eitt_pkg::LW-1:0] == my_idx)
                             : (rid == s_in.key);
  assign hit   = valid && match && !s_in.found;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_out.act <= 1'b0;
    end else begin
      s_out.act <= s_in.act;
    end
    s_out.by_loc <= s_in.by_loc;
    s_out.rng    <= s_in.rng;
    s_out.key    <= s_in.key;
    s_out.found  <= s_in.found | hit;
    s_out.loc    <= hit ? my_idx : s_in.loc;
    s_out.rid    <= hit ? rid : s_in.rid;
  end
endmodule

FILE: hdl/entity_id_translation_table.sv
// ---------------------------------------------------------------------------
// entity_id_translation_table: remote to local id translation table
// A row of ENTRIES cells is searched by a beat that moves one cell a cycle;
// a high-water mark and a freed-id stack (RAM) hand out local ids.
// ---------------------------------------------------------------------------
// Order: actions that walk the chain (all but set client and unused codes) pass
//   S_SRCH, then S_DEC, S_POP and S_OUT; the others go straight to S_DEC.
// Throughput: one beat at a time; busy is high through the strobe cycle, and a
//   new beat is accepted only once the block is idle again.
// The chain length sets the search time; the stack RAM read adds the S_POP state.
// Reset: rst (synchronous) clears all valid marks and the freed count and
//   sets the high mark to one. Results cannot be stalled by the receiver.
module entity_id_translation_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic signed [31:0] id_in,
  output logic        done,
  output logic signed [31:0] id_out,
  output logic [2:0]  status,
  output logic        is_client
);
  localparam int N  = eitt_pkg::ENTRIES;
  localparam int LW = eitt_pkg::LW;
  localparam int CW = eitt_pkg::CW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SRCH = 5'b00010,   // beat walks the chain
    S_DEC  = 5'b00100,   // decide, issue stack read/write
    S_POP  = 5'b01000,   // stack data ready
    S_OUT  = 5'b10000    // strobe the result
  } state_t;

  state_t state;
  logic [2:0]  act;
  logic [31:0] key;
  logic [CW-1:0] cnt;
  logic [CW-1:0] freed_count;
  logic [CW-1:0] high_mark;

  eitt_pkg::eitt_wr_t   wr;
  eitt_pkg::eitt_srch_t chain [N+1];
  logic                 fnd;
  logic [LW-1:0]        floc;
  logic [31:0]          frid;

  // stack RAM port
  logic           st_we;
  logic [LW-1:0]  st_addr;
  logic [LW-1:0]  st_wdata;
  logic [LW-1:0]  st_rdata;

  // facts remembered from S_DEC for the result
  logic          wr_new_mark;
  logic [LW-1:0] new_loc;

  logic need_srch;
  logic by_loc;

  assign busy = (state != S_IDLE);

  // upstream and remove-by-local look up the entry by its index
  assign by_loc    = (action == eitt_pkg::ACT_UP) || (action == eitt_pkg::ACT_RM_LOC);
  assign need_srch = (action == eitt_pkg::ACT_DOWN) || (action == eitt_pkg::ACT_FREE) ||
                     (action == eitt_pkg::ACT_RM_REM) || by_loc;

  // search beat enters at the head when the beat is accepted
  always_comb begin
    chain[0].act    = start && !busy;
    chain[0].by_loc = by_loc;
    chain[0].rng    = (id_in[31:LW] == '0);
    chain[0].found  = 1'b0;
    chain[0].loc    = '0;
    chain[0].key    = id_in;
    chain[0].rid    = '0;
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    eitt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .my_idx(LW'(g)),
      .wr    (wr),
      .s_in  (chain[g]),
      .s_out (chain[g+1])
    );
  end

  // capture the beat's outcome as it leaves the tail
  always_ff @(posedge clk) begin
    if (chain[N].act) begin
      fnd  <= chain[N].found;
      floc <= chain[N].loc;
      frid <= chain[N].rid;
    end
  end

  eitt_ram #(.WIDTH(LW), .DEPTH(N)) u_stack (
    .clk  (clk),
    .we   (st_we),
    .addr (st_addr),
    .wdata(st_wdata),
    .rdata(st_rdata)
  );

  // decision logic in S_DEC / S_POP
  always_comb begin
    wr       = '0;
    wr.rid   = key;
    st_we    = 1'b0;
    st_addr  = freed_count[LW-1:0] - LW'(1);
    st_wdata = floc;
    if (state == S_DEC) begin
      unique case (act)
        eitt_pkg::ACT_DOWN: begin
          if (!fnd && freed_count == '0 && high_mark < CW'(N)) begin
            wr.wr = 1'b1; wr.set_v = 1'b1; wr.set_id = 1'b1;
            wr.idx = high_mark[LW-1:0];
          end
        end
        eitt_pkg::ACT_FREE: begin
          if (fnd && floc != '0 && !(CW'(floc) == high_mark - CW'(1)) &&
              freed_count < CW'(N)) begin
            st_we   = 1'b1;
            st_addr = freed_count[LW-1:0];
          end
        end
        eitt_pkg::ACT_RM_REM, eitt_pkg::ACT_RM_LOC: begin
          if (fnd) begin
            wr.wr = 1'b1; wr.idx = floc;
          end
        end
        eitt_pkg::ACT_CLIENT: begin
          wr.wr = 1'b1; wr.set_v = 1'b1; wr.set_id = 1'b1; wr.idx = '0;
        end
        default: ;
      endcase
    end else if (state == S_POP && act == eitt_pkg::ACT_DOWN && !fnd &&
                 freed_count != '0) begin
      // rdata holds the popped id; the count drops as S_POP ends
      wr.wr = 1'b1; wr.set_v = 1'b1; wr.set_id = 1'b1; wr.idx = st_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      freed_count <= '0;
      high_mark   <= CW'(1);
      cnt         <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            act   <= action;
            key   <= id_in;
            cnt   <= '0;
            state <= need_srch ? S_SRCH : S_DEC;
          end
        end
        S_SRCH: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(N - 1)) begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          state <= S_POP;
          if (act == eitt_pkg::ACT_DOWN && !fnd && freed_count == '0 &&
              high_mark < CW'(N)) begin
            high_mark <= high_mark + CW'(1);
          end
          if (act == eitt_pkg::ACT_FREE && fnd && floc != '0) begin
            if (CW'(floc) == high_mark - CW'(1)) begin
              high_mark <= high_mark - CW'(1);
            end else if (freed_count < CW'(N)) begin
              freed_count <= freed_count + CW'(1);
            end
          end
        end
        S_POP: begin
          state <= S_OUT;
          done  <= 1'b1;
          if (act == eitt_pkg::ACT_DOWN && !fnd && freed_count != '0) begin
            freed_count <= freed_count - CW'(1);
          end
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result registers, loaded as the strobe rises
  always_ff @(posedge clk) begin
    if (state == S_POP) begin
      id_out    <= key;
      status    <= eitt_pkg::ST_MISS;
      is_client <= 1'b0;
      unique case (act)
        eitt_pkg::ACT_DOWN: begin
          if (fnd) begin
            id_out <= 32'(floc); status <= eitt_pkg::ST_HIT; is_client <= (floc == '0);
          end else if (freed_count != '0) begin
            id_out <= 32'(st_rdata); status <= eitt_pkg::ST_NEW;
            is_client <= (st_rdata == '0);
          end else if (wr_new_mark) begin
            id_out <= 32'(new_loc); status <= eitt_pkg::ST_NEW;
          end else begin
            status <= eitt_pkg::ST_FULL;
          end
        end
        eitt_pkg::ACT_UP: begin
          if (fnd) begin
            id_out <= frid; status <= eitt_pkg::ST_HIT; is_client <= (floc == '0);
          end
        end
        eitt_pkg::ACT_FREE, eitt_pkg::ACT_RM_REM: begin
          if (fnd) begin
            id_out <= 32'(floc); status <= eitt_pkg::ST_DONE;
          end
        end
        eitt_pkg::ACT_RM_LOC: begin
          if (fnd) begin
            id_out <= frid; status <= eitt_pkg::ST_DONE;
          end
        end
        eitt_pkg::ACT_CLIENT: begin
          id_out <= '0; status <= eitt_pkg::ST_DONE; is_client <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DEC) begin
      wr_new_mark <= (act == eitt_pkg::ACT_DOWN) && !fnd && freed_count == '0 &&
                     high_mark < CW'(N);
      new_loc     <= high_mark[LW-1:0];
    end
  end

  // assertions
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    freed_count <= CW'(N))
    else $error("freed count overflow");
  a_mark_range: assert property (@(posedge clk) disable iff (rst)
    high_mark >= CW'(1) && high_mark <= CW'(N))
    else $error("high mark out of range");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("strobe longer than one cycle");
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("strobe while idle");
endmodule

FILE: tb/sv/tb_entity_id_translation_table.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_entity_id_translation_table: self-checking bench for the id table
// Directed beats, then random blocks over remote-id pools of varied size,
// with idle gaps. Each beat is predicted on acceptance and checked on strobe.
// ---------------------------------------------------------------------------
module tb_entity_id_translation_table;

  // unused action codes, expected to be ignored
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;
  localparam int MAX_SHOWN = 10;

  typedef struct {
    logic [2:0]  act;
    logic [31:0] id;
  } cmd_t;

  typedef struct {
    logic [31:0] id;
    logic [2:0]  st;
    logic        cl;
  } xlate_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [2:0]        action = '0;
  logic signed [31:0] id_in = '0;
  logic              busy, done, is_client;
  logic signed [31:0] id_out;
  logic [2:0]        status;

  entity_id_translation_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .id_in(id_in), .done(done), .id_out(id_out), .status(status),
    .is_client(is_client)
  );

  always #5 clk = ~clk;

  // Shadow of the table and allocator.
  logic        sh_valid [eitt_pkg::ENTRIES];
  logic [31:0] sh_rid   [eitt_pkg::ENTRIES];
  logic [7:0]  sh_stack [eitt_pkg::ENTRIES];
  int unsigned sh_fcnt, sh_mark;

  cmd_t   pending_cmds[$];
  xlate_t expected_results[$];
  int     n_queued = 0, n_accepted = 0, n_errors = 0;
  logic   fill_done = 1'b0;

  function automatic int find_remote(logic [31:0] r);
    for (int i = 0; i < eitt_pkg::ENTRIES; i++)
      if (sh_valid[i] && sh_rid[i] == r) return i;
    return -1;
  endfunction

  function automatic void release_local(int unsigned loc);
    if (loc == 0) return;
    if (sh_mark > 0 && loc == sh_mark - 1) sh_mark--;
    else if (sh_fcnt < eitt_pkg::ENTRIES) begin
      sh_stack[sh_fcnt] = loc[7:0];
      sh_fcnt++;
    end
  endfunction

  // Compute one translation and update the shadow state.
  function automatic xlate_t xlate_predict(cmd_t c);
    xlate_t r;
    int f;
    int unsigned loc;
    r.id = c.id; r.st = eitt_pkg::ST_MISS; r.cl = 1'b0;
    case (c.act)
      eitt_pkg::ACT_DOWN: begin
        f = find_remote(c.id);
        if (f >= 0) begin
          loc = f; r.st = eitt_pkg::ST_HIT;
        end else if (sh_fcnt > 0) begin
          sh_fcnt--; loc = sh_stack[sh_fcnt]; r.st = eitt_pkg::ST_NEW;
        end else if (sh_mark < eitt_pkg::ENTRIES) begin
          loc = sh_mark; sh_mark++; r.st = eitt_pkg::ST_NEW;
        end else begin
          r.st = eitt_pkg::ST_FULL;
          return r;
        end
        if (r.st == eitt_pkg::ST_NEW) begin
          sh_valid[loc] = 1'b1; sh_rid[loc] = c.id;
        end
        r.id = loc; r.cl = (loc == 0);
      end
      eitt_pkg::ACT_UP: begin
        if (c.id < eitt_pkg::ENTRIES && sh_valid[c.id[7:0]]) begin
          r.id = sh_rid[c.id[7:0]]; r.st = eitt_pkg::ST_HIT; r.cl = (c.id == 0);
        end
      end
      eitt_pkg::ACT_FREE: begin
        f = find_remote(c.id);
        if (f >= 0) begin
          release_local(f); r.id = f; r.st = eitt_pkg::ST_DONE;
        end
      end
      eitt_pkg::ACT_RM_REM: begin
        f = find_remote(c.id);
        if (f >= 0) begin
          sh_valid[f] = 1'b0; r.id = f; r.st = eitt_pkg::ST_DONE;
        end
      end
      eitt_pkg::ACT_RM_LOC: begin
        if (c.id < eitt_pkg::ENTRIES && sh_valid[c.id[7:0]]) begin
          sh_valid[c.id[7:0]] = 1'b0; r.id = sh_rid[c.id[7:0]];
          r.st = eitt_pkg::ST_DONE;
        end
      end
      eitt_pkg::ACT_CLIENT: begin
        sh_valid[0] = 1'b1; sh_rid[0] = c.id;
        r.id = '0; r.st = eitt_pkg::ST_DONE; r.cl = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(120, 20);
  endfunction

  // Driver: predicts on acceptance, then presents the next beat after a gap.
  int gap_left = 0;
  always @(posedge clk) begin
    cmd_t c;
    logic next_start;
    if (rst) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        c.act = action; c.id = id_in;
        expected_results.insert(expected_results.size(), xlate_predict(c));
        n_accepted++;
        next_start = 1'b0;
        gap_left = pick_gap();
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          // idle time counts only once the block is free again
          if (!busy && !(start && !busy)) gap_left--;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          action <= c.act;
          id_in  <= c.id;
          next_start = 1'b1;
        end
      end
      start <= next_start;
    end
  end

  // Monitor: a strobed result is taken at the edge ending its cycle.
  always @(posedge clk) begin
    xlate_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_SHOWN)
          $display("unexpected beat: id_out=%h status=%0d is_client=%b",
                   id_out, status, is_client);
      end else begin
        e = expected_results.pop_front();
        if (id_out !== e.id || status !== e.st || is_client !== e.cl) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display("mismatch: exp id=%h st=%0d cl=%b, got id=%h st=%0d cl=%b",
                     e.id, e.st, e.cl, id_out, status, is_client);
        end
      end
    end
  end

  task automatic queue_cmd(logic [2:0] a, logic [31:0] v);
    cmd_t c;
    c.act = a; c.id = v;
    pending_cmds.insert(pending_cmds.size(), c);
    n_queued++;
  endtask

  // Stimulus
  initial begin
    logic [31:0] pool[512];
    int pool_n, p, r;
    for (int i = 0; i < eitt_pkg::ENTRIES; i++) begin
      sh_valid[i] = 1'b0; sh_rid[i] = '0; sh_stack[i] = '0;
    end
    sh_fcnt = 0; sh_mark = 1;
    for (int i = 0; i < 512; i++) pool[i] = $urandom;
    pool[0] = 32'h8000_0000; pool[1] = 32'h7fff_ffff;
    pool[2] = 32'hffff_ffff; pool[3] = 32'h0000_0000;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, every action, special cases
    queue_cmd(eitt_pkg::ACT_UP, 32'd0);             // local 0 not valid yet
    queue_cmd(eitt_pkg::ACT_FREE, 32'h1234_5678);   // unknown remote id
    queue_cmd(eitt_pkg::ACT_DOWN, 32'h8000_0000);   // allocate local 1
    queue_cmd(eitt_pkg::ACT_DOWN, 32'h7fff_ffff);   // local 2
    queue_cmd(eitt_pkg::ACT_DOWN, 32'hffff_ffff);   // local 3
    queue_cmd(eitt_pkg::ACT_DOWN, 32'h8000_0000);   // hit
    queue_cmd(eitt_pkg::ACT_UP, 32'd2);
    queue_cmd(eitt_pkg::ACT_UP, 32'd255);           // in range, not valid
    queue_cmd(eitt_pkg::ACT_UP, 32'hffff_ffff);     // out of range
    queue_cmd(eitt_pkg::ACT_CLIENT, 32'h7fff_ffff); // duplicate of local 2
    queue_cmd(eitt_pkg::ACT_DOWN, 32'h7fff_ffff);   // lowest local wins: 0
    queue_cmd(eitt_pkg::ACT_UP, 32'd0);
    queue_cmd(eitt_pkg::ACT_FREE, 32'h7fff_ffff);   // freeing local zero
    queue_cmd(eitt_pkg::ACT_FREE, 32'hffff_ffff);   // top id lowers the mark
    queue_cmd(eitt_pkg::ACT_FREE, 32'h8000_0000);   // pushed on the stack
    queue_cmd(eitt_pkg::ACT_DOWN, 32'h0000_0000);   // pops the stack
    queue_cmd(eitt_pkg::ACT_RM_REM, 32'h0000_0000);
    queue_cmd(eitt_pkg::ACT_RM_REM, 32'h0000_0000); // now unknown
    queue_cmd(eitt_pkg::ACT_RM_LOC, 32'd0);
    queue_cmd(eitt_pkg::ACT_RM_LOC, 32'd0);         // already cleared
    queue_cmd(eitt_pkg::ACT_RM_LOC, 32'h8000_0100); // out of range
    queue_cmd(ACT_SPARE6, 32'h5555_aaaa);
    queue_cmd(ACT_SPARE7, 32'haaaa_5555);

    // random blocks; large pools drive the table to full, small ones hit
    for (int b = 0; b < 18; b++) begin
      pool_n = (b % 3 == 1) ? 300 + $urandom_range(200) : $urandom_range(40, 4);
      for (int k = 0; k < 100; k++) begin
        p = $urandom_range(99);
        r = $urandom_range(pool_n - 1);
        if (p < 45)      queue_cmd(eitt_pkg::ACT_DOWN, pool[r]);
        else if (p < 58) queue_cmd(eitt_pkg::ACT_UP, ($urandom_range(9) == 0) ? $urandom
                                   : $urandom_range(eitt_pkg::ENTRIES - 1));
        else if (p < 72) queue_cmd(eitt_pkg::ACT_FREE, pool[r]);
        else if (p < 80) queue_cmd(eitt_pkg::ACT_RM_REM, pool[r]);
        else if (p < 88) queue_cmd(eitt_pkg::ACT_RM_LOC, ($urandom_range(9) == 0) ? $urandom
                                   : $urandom_range(eitt_pkg::ENTRIES - 1));
        else if (p < 92) queue_cmd(eitt_pkg::ACT_CLIENT, pool[r]);
        else if (p < 95) queue_cmd(3'($urandom_range(7)), $urandom);
        else             queue_cmd(eitt_pkg::ACT_DOWN, $urandom);
      end
    end
    fill_done = 1'b1;
  end

  // End of run
  initial begin
    wait (fill_done);
    wait (n_accepted == n_queued && expected_results.size() == 0);
    repeat (eitt_pkg::ENTRIES + 40) @(posedge clk);
    if (n_errors == 0 && expected_results.size() == 0)
      $display("tb_entity_id_translation_table: done, clean");
    else
      $display("tb_entity_id_translation_table: done, errors");
    $finish;
  end

  initial begin
    #30ms;
    $display("tb_entity_id_translation_table: done, errors");
    $finish;
  end

endmodule

FILE: sim.f
hdl/eitt_pkg.sv
hdl/eitt_ram.sv
hdl/eitt_cell.sv
hdl/entity_id_translation_table.sv
tb/sv/tb_entity_id_translation_table.sv
